// ----- design/lkvc_pkg.sv -----
package lkvc_pkg;

    localparam int DATA_W   = 32;
    localparam int CAP_BITS = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0]   MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // update command for one slot
    typedef struct packed {
        logic update;      // a request changes the table this cycle
        logic sel;         // this slot is the target of the request
        logic write_key;   // target takes the new key and becomes valid
        logic write_value; // target takes the new value
        logic age_all;     // insert: every other valid slot ages
    } slot_cmd_t;

    // status reported by one slot
    typedef struct packed {
        logic valid;
        logic match;
        logic oldest;
    } slot_stat_t;

endpackage

// ----- design/lru_key_value_cache_unit.sv -----
// Fully associative key-value cache with least-recently-used replacement.
//
// Request channel: drive req_type (0 get, 1 put), key and value_in with start
// high; the word is taken at any rising edge where start is high and busy is
// low. busy never rises, so one request can be issued every cycle.
//
// Result channel: done pulses for one cycle with found, value_out, evicted
// and evicted_key. The receiver cannot stall; results must be taken as they
// appear. Requests pass the request register, then the result register that
// drives done. Throughput is one request per cycle, set by the single pass
// of parallel key compare and rank update over all slots.
//
// Each slot holds a recency rank (0 = most recent). A put miss with the table
// at capacity replaces the slot with the highest rank and reports its key.
//
// cfg_write/cfg_data set the capacity (0 acts as 1, above ENTRIES saturates).
// Write it only while no request is in flight.
// Reset empties the table and sets the capacity to 16; it takes effect at
// once with no clearing pass.
module lru_key_value_cache_unit #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic signed [31:0]  key,
    input  logic signed [31:0]  value_in,
    input  logic                cfg_write,
    input  logic [4:0]          cfg_data,
    output logic                done,
    output logic                found,
    output logic signed [31:0]  value_out,
    output logic                evicted,
    output logic signed [31:0]  evicted_key
);
    import lkvc_pkg::*;

    localparam int KEY_W  = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LIVE_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (LIVE_W > CAP_BITS) ? LIVE_W : CAP_BITS;

    // configuration
    logic [CAP_BITS-1:0] cap_reg;

    // request register
    logic              req_valid_reg;
    logic              req_type_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [DATA_W-1:0] req_value_reg;

    // table occupancy
    logic [LIVE_W-1:0] live_reg, live_next;

    // result register
    logic              res_valid_reg;
    logic              found_reg, found_next;
    logic [DATA_W-1:0] value_out_reg, value_out_next;
    logic              evicted_reg, evicted_next;
    logic [DATA_W-1:0] ev_key_reg, ev_key_next;

    // slot array
    slot_cmd_t         slot_cmd   [ENTRIES];
    slot_stat_t        slot_stat  [ENTRIES];
    logic [RANK_W-1:0] slot_rank  [ENTRIES];
    logic [KEY_W-1:0]  slot_key   [ENTRIES];
    logic [DATA_W-1:0] slot_value [ENTRIES];

    logic [ENTRIES-1:0] valid_vec, match_vec, oldest_vec, free_sel, target_vec;
    logic               hit, is_put, at_capacity, need_evict, do_update, free_seen;
    logic [RANK_W-1:0]  hit_rank, oldest_rank;
    logic [DATA_W-1:0]  hit_value;
    logic [KEY_W-1:0]   victim_key;

    assign busy = 1'b0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : gen_slot
            lkvc_slot #(
                .RANK_W (RANK_W),
                .KEY_W  (KEY_W)
            ) u_slot (
                .clk          (clk),
                .rst_n        (rst_n),
                .key          (req_key_reg),
                .value_in     (req_value_reg),
                .hit_rank     (hit_rank),
                .oldest_rank  (oldest_rank),
                .cmd          (slot_cmd[g]),
                .stat         (slot_stat[g]),
                .rank         (slot_rank[g]),
                .stored_key   (slot_key[g]),
                .stored_value (slot_value[g])
            );
            assign valid_vec[g]  = slot_stat[g].valid;
            assign match_vec[g]  = slot_stat[g].match;
            assign oldest_vec[g] = slot_stat[g].oldest;
        end
    endgenerate

    assign oldest_rank = RANK_W'(live_reg - LIVE_W'(1));
    assign is_put      = (req_type_reg == REQ_PUT);
    assign hit         = |match_vec;

    // capacity 0 acts as 1; a full table always counts as at capacity
    assign at_capacity = (live_reg == LIVE_W'(ENTRIES)) ||
                         ((cap_reg == '0) ? (live_reg != '0)
                                          : (CMP_W'(live_reg) >= CMP_W'(cap_reg)));
    assign need_evict  = is_put && !hit && at_capacity;
    assign do_update   = req_valid_reg && (hit || is_put);

    always_comb
    begin
        hit_rank   = '0;
        hit_value  = '0;
        victim_key = '0;
        free_sel   = '0;
        free_seen  = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                hit_rank  = hit_rank | slot_rank[i];
                hit_value = hit_value | slot_value[i];
            end
            if (oldest_vec[i])
            begin
                victim_key = victim_key | slot_key[i];
            end
            if (!valid_vec[i] && !free_seen)
            begin
                free_sel[i] = 1'b1;
                free_seen   = 1'b1;
            end
        end
    end

    assign target_vec = hit ? match_vec : (need_evict ? oldest_vec : free_sel);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_cmd[i].update      = do_update;
            slot_cmd[i].sel         = target_vec[i];
            slot_cmd[i].write_key   = !hit;
            slot_cmd[i].write_value = is_put;
            slot_cmd[i].age_all     = !hit;
        end
    end

    always_comb
    begin
        live_next      = live_reg;
        found_next     = hit;
        evicted_next   = need_evict;
        ev_key_next    = need_evict ? DATA_W'(victim_key) : '0;
        value_out_next = '0;
        if (!is_put)
        begin
            value_out_next = hit ? hit_value : MISS_VALUE;
        end
        if (req_valid_reg && is_put && !hit && !at_capacity)
        begin
            live_next = live_reg + LIVE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            live_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            req_valid_reg <= start && !busy;
            res_valid_reg <= req_valid_reg;
            live_reg      <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_type_reg  <= req_type;
            req_key_reg   <= key[KEY_W-1:0];
            req_value_reg <= value_in;
        end
        found_reg     <= found_next;
        value_out_reg <= value_out_next;
        evicted_reg   <= evicted_next;
        ev_key_reg    <= ev_key_next;
    end

    assign done        = res_valid_reg;
    assign found       = found_reg;
    assign value_out   = value_out_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = ev_key_reg;

`ifndef SYNTHESIS
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key matches more than one slot");

    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == LIVE_W'($countones(valid_vec)))
        else $error("live count disagrees with valid slots");

    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg != '0) |-> $onehot(oldest_vec))
        else $error("no unique least recent slot");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && need_evict) |=> (done && evicted && !found))
        else $error("eviction not reported as a put miss");
`endif

endmodule

// ----- design/lkvc_slot.sv -----
module lkvc_slot #(
    parameter int RANK_W = 4,
    parameter int KEY_W  = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [KEY_W-1:0]           key,
    input  logic [lkvc_pkg::DATA_W-1:0] value_in,
    input  logic [RANK_W-1:0]          hit_rank,
    input  logic [RANK_W-1:0]          oldest_rank,
    input  lkvc_pkg::slot_cmd_t        cmd,
    output lkvc_pkg::slot_stat_t       stat,
    output logic [RANK_W-1:0]          rank,
    output logic [KEY_W-1:0]           stored_key,
    output logic [lkvc_pkg::DATA_W-1:0] stored_value
);
    import lkvc_pkg::*;

    logic              valid_reg, valid_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] value_reg, value_next;

    assign stat.valid   = valid_reg;
    assign stat.match   = valid_reg && (key_reg == key);
    assign stat.oldest  = valid_reg && (rank_reg == oldest_rank);
    assign rank         = rank_reg;
    assign stored_key   = key_reg;
    assign stored_value = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.update)
        begin
            if (cmd.sel)
            begin
                rank_next = '0;
                if (cmd.write_key)
                begin
                    valid_next = 1'b1;
                    key_next   = key;
                end
                if (cmd.write_value)
                begin
                    value_next = value_in;
                end
            end
            else if (valid_reg && (cmd.age_all || (rank_reg < hit_rank)))
            begin
                // age by one; ranks stay a permutation of the live entries
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// ----- dv/lru_key_value_cache_unit_tb.sv -----
module lru_key_value_cache_unit_tb;

    import lkvc_pkg::*;

    localparam int ENTRIES    = 16;
    localparam int POOL_MAX   = 24;
    localparam int N_PHASES   = 10;
    localparam int PHASE_REQS = 40;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } cache_reply_t;

    typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              req;
        logic [DATA_W-1:0] req_key;
        logic [DATA_W-1:0] req_val;
        logic              typed;
        cache_reply_t      want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [DATA_W-1:0]   req_key;
    logic [DATA_W-1:0]   req_val;
    logic                cfg_write;
    logic [CAP_BITS-1:0] cfg_data;
    logic                done;
    logic                found;
    logic [DATA_W-1:0]   value_out;
    logic                evicted;
    logic [DATA_W-1:0]   evicted_key;

    // shadow copy of the table
    bit                  shadow_valid [ENTRIES];
    logic [DATA_W-1:0]   shadow_key   [ENTRIES];
    logic [DATA_W-1:0]   shadow_value [ENTRIES];
    int unsigned         shadow_rank  [ENTRIES];
    int unsigned         shadow_live;
    logic [CAP_BITS-1:0] shadow_cap;

    cache_reply_t replies_due[$];
    int           n_errors;
    int           n_reqs;
    int           n_hits;
    int           n_evictions;
    int           n_cap_writes;

    lru_key_value_cache_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .key        (req_key),
        .value_in   (req_val),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .done       (done),
        .found      (found),
        .value_out  (value_out),
        .evicted    (evicted),
        .evicted_key(evicted_key)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
        $display("[lru_key_value_cache_unit] ERROR");
        $finish;
    end

    // slot s becomes newest; valid slots younger than limit age by one
    function automatic void make_newest(int s, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i != s && shadow_valid[i] && shadow_rank[i] < limit)
                shadow_rank[i]++;
        end
        shadow_rank[s] = 0;
    endfunction

    task automatic lru_lookup_update(input logic rt, input logic [DATA_W-1:0] k,
                                     input logic [DATA_W-1:0] v, output cache_reply_t r);
        int          hit;
        int          slot;
        int unsigned lim;
        int unsigned best;
        r    = '0;
        hit  = -1;
        slot = -1;
        best = 0;
        lim  = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : shadow_cap);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == k)
                hit = i;
        end
        if (hit >= 0)
        begin
            r.found = 1'b1;
            n_hits++;
            if (rt == REQ_PUT)
                shadow_value[hit] = v;
            else
                r.value = shadow_value[hit];
            make_newest(hit, shadow_rank[hit]);
        end
        else if (rt == REQ_GET)
        begin
            r.value = MISS_VALUE;
        end
        else
        begin
            if (shadow_live >= lim)
            begin
                // replace the oldest live slot, first one wins a tie
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > best))
                    begin
                        slot = i;
                        best = shadow_rank[i];
                    end
                end
                if (slot >= 0)
                begin
                    r.evicted     = 1'b1;
                    r.evicted_key = shadow_key[slot];
                    n_evictions++;
                end
            end
            if (slot < 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot < 0 && !shadow_valid[i])
                        slot = i;
                end
                if (slot >= 0)
                    shadow_live++;
            end
            if (slot >= 0)
            begin
                shadow_valid[slot] = 1'b1;
                shadow_key[slot]   = k;
                shadow_value[slot] = v;
                make_newest(slot, 32'hFFFF_FFFF);
            end
        end
    endtask

    // hold start until the word is taken, then log the reply it owes
    task automatic send_request(input logic rt, input logic [DATA_W-1:0] k,
                                input logic [DATA_W-1:0] v, input logic typed,
                                input cache_reply_t want);
        cache_reply_t predicted;
        start    <= 1'b1;
        req_type <= rt;
        req_key  <= k;
        req_val  <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        lru_lookup_update(rt, k, v, predicted);
        replies_due.push_back(typed ? want : predicted);
        n_reqs++;
    endtask

    task automatic idle_for(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // drain the pipe, then write the capacity while nothing is in flight
    task automatic set_capacity(input logic [CAP_BITS-1:0] c);
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        cfg_write  <= 1'b0;
        shadow_cap  = c;
        n_cap_writes++;
    endtask

    always @(posedge clk)
    begin
        cache_reply_t got;
        cache_reply_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            got = '{found, value_out, evicted, evicted_key};
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected word found=%0d value=%h evicted=%0d key=%h",
                         $time, got.found, got.value, got.evicted, got.evicted_key);
                n_errors++;
            end
            else
            begin
                exp_r = replies_due.pop_front();
                if (got !== exp_r)
                begin
                    $display("%0t: mismatch expected found=%0d value=%h evicted=%0d key=%h",
                             $time, exp_r.found, exp_r.value, exp_r.evicted,
                             exp_r.evicted_key);
                    $display("%0t:          actual   found=%0d value=%h evicted=%0d key=%h",
                             $time, got.found, got.value, got.evicted, got.evicted_key);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t           dir_tab[$];
        stim_row_t           row;
        logic [CAP_BITS-1:0] cap_plan [N_PHASES];
        logic [DATA_W-1:0]   key_pool [POOL_MAX];
        logic [DATA_W-1:0]   k;
        int                  pool_n;
        int                  pick;
        bit                  gaps_on;

        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = REQ_GET;
        req_key   = '0;
        req_val   = '0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        n_errors     = 0;
        n_reqs       = 0;
        n_hits       = 0;
        n_evictions  = 0;
        n_cap_writes = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
        end
        shadow_live = 0;
        shadow_cap  = CAP_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extreme keys and values, update on hit
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'h0000_0000, 32'h0, 1'b1,
                            '{1'b0, MISS_VALUE, 1'b0, 32'h0}});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                            '{1'b0, 32'h0, 1'b0, 32'h0}});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                            '{1'b0, 32'h0, 1'b0, 32'h0}});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'h8000_0000, 32'h0, 1'b1,
                            '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                            '{1'b1, 32'h8000_0000, 1'b0, 32'h0}});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
                            '{1'b1, 32'h0, 1'b0, 32'h0}});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'h8000_0000, 32'h0, 1'b1,
                            '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'hFFFF_FFFF, 32'h0, 1'b1,
                            '{1'b0, MISS_VALUE, 1'b0, 32'h0}});
        // capacity of zero acts as one, and sits below the two live entries
        dir_tab.push_back('{ROW_CAP, REQ_GET, 32'h0, 32'd0, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'd5, 32'd55, 1'b1,
                            '{1'b0, 32'h0, 1'b1, 32'h7FFF_FFFF}});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'd6, 32'd66, 1'b1,
                            '{1'b0, 32'h0, 1'b1, 32'h8000_0000}});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'd5, 32'h0, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, '0});
        // oversize capacity saturates
        dir_tab.push_back('{ROW_CAP, REQ_GET, 32'h0, 32'd31, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'h0, 32'h0, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'd5, 32'hAAAA_AAAA, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'd6, 32'h0, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'h5555_5555, 32'h5555_5555, 1'b0, '0});
        dir_tab.push_back('{ROW_CAP, REQ_GET, 32'h0, 32'd1, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'd1, 32'd1, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'h0, 32'h0, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_PUT, 32'd2, 32'd2, 1'b0, '0});
        dir_tab.push_back('{ROW_REQ, REQ_GET, 32'd1, 32'h0, 1'b0, '0});

        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.kind == ROW_CAP)
                set_capacity(row.req_val[CAP_BITS-1:0]);
            else
                send_request(row.req, row.req_key, row.req_val, row.typed, row.want);
        end

        // fill at full size, then drop capacity under the live count
        cap_plan = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd9, 5'd2, 5'd12, 5'd16};
        cap_plan[6] = CAP_BITS'($urandom_range(2, 15));

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_capacity(cap_plan[ph]);
            pool_n  = $urandom_range(4, POOL_MAX);
            gaps_on = (ph < N_PHASES - 1) && (ph != 3);
            for (int i = 0; i < pool_n; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       key_pool[i] = $urandom_range(0, 15);
                    1:       key_pool[i] = $urandom();
                    2:       key_pool[i] = 32'h8000_0000 + $urandom_range(0, 7);
                    default: key_pool[i] = 32'h7FFF_FFF8 + $urandom_range(0, 7);
                endcase
            end
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if (gaps_on && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 19));
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                else if (pick < 90)
                    k = key_pool[$urandom_range(0, pool_n - 1)] ^ (32'h1 << $urandom_range(0, 31));
                else
                    k = $urandom();
                send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, k, $urandom(),
                             1'b0, '0);
            end
        end

        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Ran %0d get/put requests: %0d hits, %0d evictions", n_reqs, n_hits,
                 n_evictions);
        $display("Capacity rewritten %0d times across zero, one, mid, full and oversize",
                 n_cap_writes);
        if (n_errors == 0)
            $display("[lru_key_value_cache_unit] OK");
        else
            $display("[lru_key_value_cache_unit] ERROR");
        $finish;
    end

endmodule
